/* rtl/signed_count_rle_decoder_unit_macros.svh */
// Assertion macros used by the checker file of the run-length decoder.
`ifndef SIGNED_COUNT_RLE_DECODER_UNIT_MACROS_SVH
`define SIGNED_COUNT_RLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define SCRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("run-length decoder check failed");

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define SCRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("run-length decoder check failed");

`endif

/* rtl/scrd_pkg.sv */
// Package: lane counts, widths and state codes of the run-length decoder.
package scrd_pkg;

    localparam int OUT_LANES   = 4;
    localparam int LANE_FIELDS = 4;
    // Effective lane count, clamped to the four lane fields.
    localparam int LANE_NUM    = (OUT_LANES < 1) ? 1 :
                                 ((OUT_LANES > LANE_FIELDS) ? LANE_FIELDS : OUT_LANES);

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int BCNT_W  = 3;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [3:0] {
        ST_HDR  = 4'b0001,
        ST_REP  = 4'b0010,
        ST_LIT  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

/* rtl/scrd_in_if.sv */
// Interface: compressed byte channel into the decoder.
interface scrd_in_if;
    logic                 valid;
    logic                 ready;
    logic [scrd_pkg::BYTE_W-1:0] in_byte;
    logic                 last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

/* rtl/scrd_out_if.sv */
// Interface: decoded result channel out of the decoder.
interface scrd_out_if;
    logic                        valid;
    logic                        ready;
    logic [scrd_pkg::BYTE_W-1:0] lane0;
    logic [scrd_pkg::BYTE_W-1:0] lane1;
    logic [scrd_pkg::BYTE_W-1:0] lane2;
    logic [scrd_pkg::BYTE_W-1:0] lane3;
    logic [scrd_pkg::BCNT_W-1:0] byte_count;
    logic                        run_end;

    modport source (output valid, output lane0, output lane1, output lane2, output lane3,
                    output byte_count, output run_end, input ready);
    modport sink   (input valid, input lane0, input lane1, input lane2, input lane3,
                    input byte_count, input run_end, output ready);
endinterface

/* rtl/signed_count_rle_decoder_unit.sv */
// Top level: signed-count run-length decoder with one shared count/subtract unit.
//
// Usage:
//   i_in  carries one compressed byte per transfer (in_byte, last_in).
//   o_out carries decoded results of up to four bytes (lane0..lane3),
//   with byte_count valid lanes from lane0 and run_end on the last result
//   caused by one input byte. Lanes at or above byte_count read as zero.
// Flow:
//   A header byte gives no result. A literal byte gives its result in the
//   output register in the cycle after its transfer; the next byte may
//   transfer in that same cycle if the output is free. A repeat byte of
//   count c enters an emit phase: the shared unit takes min(left, 4) from
//   the remaining count for each result, one result per cycle while the
//   output register is free, until all c bytes are out, and i_in is held
//   off throughout. Literals sustain one byte per cycle while the output is free.
// Reset: header mode, count zero, output register empty.
// Receiver stall: the output register holds its result; the emit phase
//   and every input transfer wait until the register is free again.
// last_in: after its byte is processed, drop any open token and return
//   to header mode; a repeat byte still has its run emitted first.
module signed_count_rle_decoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scrd_in_if.sink          i_in,
    scrd_out_if.source       o_out
);

    scrd_pkg::t_state                  r_state, n_state;
    logic [scrd_pkg::COUNT_W-1:0]      r_cnt, n_cnt;
    scrd_pkg::t_byte                   r_byte, n_byte;
    logic                              r_out_valid, n_out_valid;
    scrd_pkg::t_byte                   r_lane [scrd_pkg::LANE_FIELDS];
    scrd_pkg::t_byte                   n_lane [scrd_pkg::LANE_FIELDS];
    logic [scrd_pkg::BCNT_W-1:0]       r_bcnt, n_bcnt;
    logic                              r_run_end, n_run_end;

    logic                              w_out_free;
    logic                              w_in_xfer;
    logic [scrd_pkg::BCNT_W-1:0]       w_take;
    logic [scrd_pkg::COUNT_W-1:0]      w_rest;

    // Output register is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state != scrd_pkg::ST_EMIT) && w_out_free;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // Shared unit: compare the remaining count to the lane count and subtract.
    always_comb begin
        if (r_cnt < scrd_pkg::COUNT_W'(scrd_pkg::LANE_NUM)) begin
            w_take = r_cnt[scrd_pkg::BCNT_W-1:0];
        end else begin
            w_take = scrd_pkg::BCNT_W'(scrd_pkg::LANE_NUM);
        end
        w_rest = r_cnt - scrd_pkg::COUNT_W'(w_take);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        n_out_valid = r_out_valid && !o_out.ready;
        n_lane      = r_lane;
        n_bcnt      = r_bcnt;
        n_run_end   = r_run_end;

        case (r_state)
            scrd_pkg::ST_REP: begin
                // Latch the repeat byte and start emitting; count stays.
                if (w_in_xfer) begin
                    n_byte  = i_in.in_byte;
                    n_state = scrd_pkg::ST_EMIT;
                end
            end
            scrd_pkg::ST_LIT: begin
                if (w_in_xfer) begin
                    n_out_valid = 1'b1;
                    n_lane[0]   = i_in.in_byte;
                    for (int i = 1; i < scrd_pkg::LANE_FIELDS; i++) begin
                        n_lane[i] = '0;
                    end
                    n_bcnt    = scrd_pkg::BCNT_W'(1);
                    n_run_end = 1'b1;
                    if (r_cnt == '0 || i_in.last_in) begin
                        n_state = scrd_pkg::ST_HDR;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt - scrd_pkg::COUNT_W'(1);
                    end
                end
            end
            scrd_pkg::ST_EMIT: begin
                // One result per cycle while the output register is free.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    for (int i = 0; i < scrd_pkg::LANE_FIELDS; i++) begin
                        n_lane[i] = (scrd_pkg::BCNT_W'(i) < w_take) ? r_byte : '0;
                    end
                    n_bcnt    = w_take;
                    n_run_end = (w_rest == '0);
                    n_cnt     = w_rest;
                    if (w_rest == '0) begin
                        n_state = scrd_pkg::ST_HDR;
                    end
                end
            end
            default: begin
                // Header mode: read the byte as a signed count.
                if (w_in_xfer) begin
                    if (i_in.in_byte == '0 || i_in.last_in) begin
                        n_state = scrd_pkg::ST_HDR;
                        n_cnt   = '0;
                    end else if (!i_in.in_byte[scrd_pkg::BYTE_W-1]) begin
                        n_state = scrd_pkg::ST_REP;
                        n_cnt   = i_in.in_byte[scrd_pkg::COUNT_W-1:0];
                    end else begin
                        // |c| - 1 is 255 - b, the inverted low seven bits.
                        n_state = scrd_pkg::ST_LIT;
                        n_cnt   = ~i_in.in_byte[scrd_pkg::COUNT_W-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scrd_pkg::ST_HDR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_lane    <= n_lane;
        r_bcnt    <= n_bcnt;
        r_run_end <= n_run_end;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.lane0      = r_lane[0];
    assign o_out.lane1      = r_lane[1];
    assign o_out.lane2      = r_lane[2];
    assign o_out.lane3      = r_lane[3];
    assign o_out.byte_count = r_bcnt;
    assign o_out.run_end    = r_run_end;

endmodule

/* rtl/scrd_checker.sv */
// Checker: port-level assertions for the run-length decoder, bound to the top level.
`include "signed_count_rle_decoder_unit_macros.svh"

module scrd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [scrd_pkg::BYTE_W-1:0] i_lane1,
    input logic [scrd_pkg::BYTE_W-1:0] i_lane2,
    input logic [scrd_pkg::BYTE_W-1:0] i_lane3,
    input logic [scrd_pkg::BCNT_W-1:0] i_byte_count,
    input logic                        i_run_end
);

    // A stalled result stays offered.
    `SCRD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // A partly filled result closes its run.
    `SCRD_ASSERT_NOW(a_short_ends, i_out_valid && i_byte_count != 3'd4, i_run_end)
    // Lanes above a single-byte result read as zero.
    `SCRD_ASSERT_NOW(a_lane_zero, i_out_valid && i_byte_count == 3'd1,
        i_lane1 == '0 && i_lane2 == '0 && i_lane3 == '0)
    // Input is held off while a repeat run is still being emitted.
    `SCRD_ASSERT_NOW(a_busy_run, i_out_valid && !i_run_end, !i_in_ready)

endmodule

bind signed_count_rle_decoder_unit scrd_checker u_scrd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_lane1      (o_out.lane1),
    .i_lane2      (o_out.lane2),
    .i_lane3      (o_out.lane3),
    .i_byte_count (o_out.byte_count),
    .i_run_end    (o_out.run_end)
);
